// ===== sv/linear_probe_hash_map_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash map
// Shared clocked property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

// same-cycle implication
`define LPHM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map package
// Field widths, command, status and slot mark codes, hash constants.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int CMD_W      = 2;
  localparam int KEY_W      = 64;
  localparam int HANDLE_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int MARK_W     = 2;

  localparam int CAPACITY_DEF     = 64;
  localparam int HANDLE_WIDTH_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXISTS    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  localparam logic [MARK_W-1:0] MARK_EMPTY     = 2'd0;
  localparam logic [MARK_W-1:0] MARK_OCCUPIED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMBSTONE = 2'd2;

  localparam logic [KEY_W-1:0] MIX_K1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_K2 = 64'hc4ceb9fe1a85ec53;
  localparam int               MIX_SHIFT = 33;

endpackage

// ===== sv/lphm_if.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map channels
// Request and response valid/ready channels with their payload fields.
// ----------------------------------------------------------------------------
interface lphm_req_if;
  logic                          valid;
  logic                          ready;
  logic [lphm_pkg::CMD_W-1:0]    command;
  logic [lphm_pkg::KEY_W-1:0]    key_axis;
  logic [lphm_pkg::KEY_W-1:0]    key_epoch;
  logic [lphm_pkg::HANDLE_W-1:0] value_handle;

  modport source (output valid, output command, output key_axis, output key_epoch,
                  output value_handle, input ready);
  modport sink   (input valid, input command, input key_axis, input key_epoch,
                  input value_handle, output ready);
endinterface

interface lphm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lphm_pkg::STATUS_W-1:0] status;
  logic [lphm_pkg::HANDLE_W-1:0] result_handle;

  modport source (output valid, output status, output result_handle, input ready);
  modport sink   (input valid, input status, input result_handle, output ready);
endinterface

// ===== sv/linear_probe_hash_map.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map
// Fixed-capacity open-addressing map with linear probing over one slot memory.
// ----------------------------------------------------------------------------
// One transaction at a time. After reset the block sweeps every slot of the
// memory to empty before it takes a request. A request then runs the two
// murmur3 finalizers on a 32x32 multiplier per key half, reads the home slot,
// reads one slot per probe on the memory read port, and then writes back and
// loads the output register, which waits while a previous response is still
// held there; the response is then offered while the next request can be
// taken. A finished response waits in an output register, and the next
// request is accepted meanwhile.
module linear_probe_hash_map #(
  parameter int CAPACITY     = lphm_pkg::CAPACITY_DEF,
  parameter int HANDLE_WIDTH = lphm_pkg::HANDLE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lphm_req_if.sink   req_i,
  lphm_rsp_if.source rsp_o
);

  localparam int AW         = $clog2(CAPACITY);
  localparam int CW         = AW + 1;
  localparam int HW         = (HANDLE_WIDTH < lphm_pkg::HANDLE_W) ? HANDLE_WIDTH
                                                                  : lphm_pkg::HANDLE_W;
  localparam int LOAD_LIMIT = CAPACITY - CAPACITY / 4;
  localparam int KW         = lphm_pkg::KEY_W;
  localparam int HKW        = KW / 2;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_HOME  = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  typedef struct packed {
    logic [lphm_pkg::MARK_W-1:0] mark;
    logic [KW-1:0]               axis;
    logic [KW-1:0]               epoch;
    logic [HW-1:0]               handle;
  } slot_t;

  function automatic logic [KW-1:0] xs(input logic [KW-1:0] v);
    return v ^ (v >> lphm_pkg::MIX_SHIFT);
  endfunction

  slot_t mem [CAPACITY];
  slot_t rd_q;
  logic  rd_en;
  logic  [AW-1:0] raddr;
  logic  we;
  logic  [AW-1:0] waddr;
  slot_t wdata;

  logic [2:0] state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  logic [lphm_pkg::CMD_W-1:0]  cmd_q;
  logic [KW-1:0]               axis_q, epoch_q;
  logic [HW-1:0]               vhandle_q;

  logic [KW-1:0] opnd_q [2];
  logic [KW-1:0] opnd_d [2];
  logic [KW-1:0] acc_q  [2];
  logic [KW-1:0] acc_d  [2];
  logic [1:0]    phase_q, phase_d;
  logic          round_q, round_d;

  logic [AW-1:0] slot_q, slot_d;
  logic [AW-1:0] n_q, n_d;
  logic          have_tomb_q, have_tomb_d;
  logic [AW-1:0] tomb_q, tomb_d;
  logic          found_q, found_d;
  logic          room_q, room_d;
  logic          where_empty_q, where_empty_d;
  logic [AW-1:0] where_q, where_d;
  logic [HW-1:0] hit_q, hit_d;

  logic [CW-1:0] live_q, live_d;
  logic [CW-1:0] nonempty_q, nonempty_d;

  logic                          out_valid_q, out_valid_d;
  logic [lphm_pkg::STATUS_W-1:0] status_q, status_d;
  logic [lphm_pkg::HANDLE_W-1:0] result_q, result_d;

  logic          req_fire;
  logic          out_free;
  logic [AW-1:0] home;
  logic          key_match;

  assign req_i.ready         = (state_q == ST_IDLE);
  assign req_fire            = req_i.valid && req_i.ready;
  assign out_free            = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.result_handle = result_q;

  assign home      = AW'(xs(acc_q[0]) ^ xs(acc_q[1]));
  assign key_match = (rd_q.axis == axis_q) && (rd_q.epoch == epoch_q);

  // finalizer lanes, one partial product per cycle
  always_comb begin
    logic [KW-1:0]  k;
    logic [KW-1:0]  op;
    logic [HKW-1:0] ma, mb;
    logic [KW-1:0]  prod;
    for (int l = 0; l < 2; l++) begin
      k        = round_q ? lphm_pkg::MIX_K2 : lphm_pkg::MIX_K1;
      op       = (round_q && phase_q == 2'd0) ? xs(acc_q[l]) : opnd_q[l];
      opnd_d[l] = op;
      case (phase_q)
        2'd0: begin
          ma = op[HKW-1:0];
          mb = k[HKW-1:0];
        end
        2'd1: begin
          ma = op[KW-1:HKW];
          mb = k[HKW-1:0];
        end
        default: begin
          ma = op[HKW-1:0];
          mb = k[KW-1:HKW];
        end
      endcase
      prod = ma * mb;
      if (phase_q == 2'd0) begin
        acc_d[l] = prod;
      end else begin
        acc_d[l] = {acc_q[l][KW-1:HKW] + prod[HKW-1:0], acc_q[l][HKW-1:0]};
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    phase_d       = phase_q;
    round_d       = round_q;
    slot_d        = slot_q;
    n_d           = n_q;
    have_tomb_d   = have_tomb_q;
    tomb_d        = tomb_q;
    found_d       = found_q;
    room_d        = room_q;
    where_empty_d = where_empty_q;
    where_d       = where_q;
    hit_d         = hit_q;
    live_d        = live_q;
    nonempty_d    = nonempty_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    status_d      = status_q;
    result_d      = result_q;
    rd_en         = 1'b0;
    raddr         = slot_q + AW'(1);
    we            = 1'b0;
    waddr         = where_q;
    wdata         = '{mark: lphm_pkg::MARK_EMPTY, axis: '0, epoch: '0, handle: '0};

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(CAPACITY - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        phase_d = 2'd0;
        round_d = 1'b0;
        if (req_fire) begin
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
        if (phase_q == 2'd2) begin
          round_d = 1'b1;
          if (round_q) begin
            state_d = ST_HOME;
          end
        end
      end
      ST_HOME: begin
        rd_en       = 1'b1;
        raddr       = home;
        slot_d      = home;
        n_d         = '0;
        have_tomb_d = 1'b0;
        state_d     = ST_PROBE;
      end
      ST_PROBE: begin
        if (rd_q.mark == lphm_pkg::MARK_EMPTY) begin
          found_d       = 1'b0;
          room_d        = 1'b1;
          where_d       = have_tomb_q ? tomb_q : slot_q;
          where_empty_d = !have_tomb_q;
          state_d       = ST_DONE;
        end else if (rd_q.mark == lphm_pkg::MARK_OCCUPIED && key_match) begin
          found_d = 1'b1;
          room_d  = 1'b1;
          where_d = slot_q;
          hit_d   = rd_q.handle;
          state_d = ST_DONE;
        end else begin
          if (rd_q.mark != lphm_pkg::MARK_OCCUPIED && !have_tomb_q) begin
            have_tomb_d = 1'b1;
            tomb_d      = slot_q;
          end
          if (n_q == AW'(CAPACITY - 1)) begin
            found_d       = 1'b0;
            room_d        = have_tomb_d;
            where_d       = tomb_d;
            where_empty_d = 1'b0;
            state_d       = ST_DONE;
          end else begin
            rd_en  = 1'b1;
            slot_d = slot_q + AW'(1);
            n_d    = n_q + AW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = lphm_pkg::STATUS_NOT_FOUND;
          result_d    = '0;
          unique case (cmd_q)
            lphm_pkg::CMD_INSERT: begin
              if (found_q) begin
                status_d = lphm_pkg::STATUS_EXISTS;
              end else if (({1'b0, nonempty_q} + (CW + 1)'(1)) >= (CW + 1)'(LOAD_LIMIT)
                           || !room_q) begin
                status_d = lphm_pkg::STATUS_FULL;
              end else begin
                we       = 1'b1;
                wdata    = '{mark: lphm_pkg::MARK_OCCUPIED, axis: axis_q,
                             epoch: epoch_q, handle: vhandle_q};
                live_d   = live_q + CW'(1);
                status_d = lphm_pkg::STATUS_OK;
                if (where_empty_q) begin
                  nonempty_d = nonempty_q + CW'(1);
                end
              end
            end
            lphm_pkg::CMD_LOOKUP: begin
              if (found_q) begin
                status_d = lphm_pkg::STATUS_OK;
                result_d = lphm_pkg::HANDLE_W'(hit_q);
              end
            end
            lphm_pkg::CMD_REMOVE: begin
              if (found_q) begin
                status_d = lphm_pkg::STATUS_OK;
                result_d = lphm_pkg::HANDLE_W'(hit_q);
                we       = 1'b1;
                wdata    = '{mark: lphm_pkg::MARK_TOMBSTONE, axis: '0, epoch: '0,
                             handle: '0};
                if (live_q != '0) begin
                  live_d = live_q - CW'(1);
                end
              end
            end
            default: begin
              status_d = lphm_pkg::STATUS_NOT_FOUND;
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      phase_q     <= 2'd0;
      round_q     <= 1'b0;
      live_q      <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
      have_tomb_q <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      phase_q     <= phase_d;
      round_q     <= round_d;
      live_q      <= live_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
      have_tomb_q <= have_tomb_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q     <= req_i.command;
      axis_q    <= req_i.key_axis;
      epoch_q   <= req_i.key_epoch;
      vhandle_q <= req_i.value_handle[HW-1:0];
      opnd_q[0] <= xs(req_i.key_axis);
      opnd_q[1] <= xs(req_i.key_epoch);
    end else if (state_q == ST_HASH) begin
      opnd_q[0] <= opnd_d[0];
      opnd_q[1] <= opnd_d[1];
    end
    if (state_q == ST_HASH) begin
      acc_q[0] <= acc_d[0];
      acc_q[1] <= acc_d[1];
    end
    slot_q        <= slot_d;
    tomb_q        <= tomb_d;
    found_q       <= found_d;
    room_q        <= room_d;
    where_empty_q <= where_empty_d;
    where_q       <= where_d;
    hit_q         <= hit_d;
    status_q      <= status_d;
    result_q      <= result_d;
  end

endmodule

// ===== sv/lphm_checker.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map checker
// Port-level properties on transaction ordering and response contents.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_assert.svh"

module lphm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [lphm_pkg::STATUS_W-1:0] status_i,
  input logic [lphm_pkg::HANDLE_W-1:0] result_handle_i
);

  logic       req_fire;
  logic       rsp_fire;
  logic [1:0] pend_q, pend_d;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // requests taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (req_fire && !rsp_fire) begin
      pend_d = pend_q + 2'd1;
    end else if (!req_fire && rsp_fire) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `LPHM_ASSERT_NOW(a_rsp_has_req, clk_i, rst_ni, rsp_valid_i, pend_q != 2'd0,
    "response without an outstanding request")

  `LPHM_ASSERT_NOW(a_one_in_work, clk_i, rst_ni, req_fire, pend_q <= 2'd1,
    "request taken while another is still in work")

  `LPHM_ASSERT_NOW(a_handle_zero, clk_i, rst_ni,
    rsp_valid_i && status_i != lphm_pkg::STATUS_OK, result_handle_i == '0,
    "nonzero handle on a failed transaction")

  `LPHM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
    rsp_valid_i && $stable(status_i) && $stable(result_handle_i),
    "stalled response changed")

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .result_handle_i (rsp_o.result_handle)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash map testbench
// Sends insert, lookup and remove requests with random gaps and checks each
// response in order against a cycle-free map model kept in the bench. The
// directed start covers empty-table misses, duplicates, wrap-around collision
// chains and tombstone reuse; the random body works a small key set so keys
// come and go; a final fill drives the table to its load limit.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = lphm_pkg::CAPACITY_DEF;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LOAD_LIMIT = SLOTS - SLOTS / 4;
  localparam int DRAIN_WAIT = SLOTS + 40;
  localparam logic [lphm_pkg::CMD_W-1:0]    CMD_UNUSED  = 2'd3;
  localparam logic [lphm_pkg::HANDLE_W-1:0] HANDLE_MASK = {lphm_pkg::HANDLE_WIDTH_DEF{1'b1}};
  localparam logic [lphm_pkg::KEY_W-1:0]    KEY_ONES    = '1;

  typedef struct packed {
    logic                          hold;
    logic [lphm_pkg::CMD_W-1:0]    cmd;
    logic [lphm_pkg::KEY_W-1:0]    axis;
    logic [lphm_pkg::KEY_W-1:0]    epoch;
    logic [lphm_pkg::HANDLE_W-1:0] handle;
  } map_op_t;

  typedef struct packed {
    logic [lphm_pkg::STATUS_W-1:0] status;
    logic [lphm_pkg::HANDLE_W-1:0] handle;
  } map_rsp_t;

  logic clk_i;
  logic rst_ni;

  lphm_req_if req_ch ();
  lphm_rsp_if rsp_ch ();

  linear_probe_hash_map u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // map model state
  logic [lphm_pkg::MARK_W-1:0]   bucket_mark   [SLOTS];
  logic [lphm_pkg::KEY_W-1:0]    bucket_axis   [SLOTS];
  logic [lphm_pkg::KEY_W-1:0]    bucket_epoch  [SLOTS];
  logic [lphm_pkg::HANDLE_W-1:0] bucket_handle [SLOTS];
  int                            live_count;
  int                            claimed_count;

  map_op_t    op_q[$];
  map_rsp_t   awaited_rsp[$];
  map_op_t    cur_op;
  logic [lphm_pkg::KEY_W-1:0] pool_axis[$];
  logic [lphm_pkg::KEY_W-1:0] pool_epoch[$];

  int total_ops;
  int sent_count;
  int rsp_count;
  int mismatches;
  int gap_left;
  int send_burst;
  int stall_left;
  int rsp_burst;

  function automatic logic [lphm_pkg::KEY_W-1:0] murmur_fold(
    input logic [lphm_pkg::KEY_W-1:0] v);
    logic [lphm_pkg::KEY_W-1:0] x;
    x = v;
    x = x ^ (x >> lphm_pkg::MIX_SHIFT);
    x = x * lphm_pkg::MIX_K1;
    x = x ^ (x >> lphm_pkg::MIX_SHIFT);
    x = x * lphm_pkg::MIX_K2;
    x = x ^ (x >> lphm_pkg::MIX_SHIFT);
    return x;
  endfunction

  function automatic logic [SLOT_W-1:0] home_bucket(input logic [lphm_pkg::KEY_W-1:0] a,
                                                     input logic [lphm_pkg::KEY_W-1:0] e);
    logic [lphm_pkg::KEY_W-1:0] h;
    h = murmur_fold(a) ^ murmur_fold(e);
    return h[SLOT_W-1:0];
  endfunction

  function automatic void find_bucket(input logic [lphm_pkg::KEY_W-1:0] a,
                                      input logic [lphm_pkg::KEY_W-1:0] e,
                                      output logic hit, output logic [SLOT_W-1:0] at,
                                      output logic room);
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] tomb;
    logic              have_tomb;
    logic              done;
    int                n;
    s = home_bucket(a, e);
    tomb = '0;
    have_tomb = 1'b0;
    done = 1'b0;
    hit = 1'b0;
    room = 1'b0;
    at = '0;
    for (n = 0; n < SLOTS; n++) begin
      if (!done) begin
        if (bucket_mark[s] == lphm_pkg::MARK_EMPTY) begin
          at = have_tomb ? tomb : s;
          room = 1'b1;
          done = 1'b1;
        end else if (bucket_mark[s] == lphm_pkg::MARK_OCCUPIED) begin
          if (bucket_axis[s] == a && bucket_epoch[s] == e) begin
            hit = 1'b1;
            at = s;
            room = 1'b1;
            done = 1'b1;
          end
        end else if (!have_tomb) begin
          have_tomb = 1'b1;
          tomb = s;
        end
        s = s + 1'b1;
      end
    end
    if (!done) begin
      at = tomb;
      room = have_tomb;
    end
  endfunction

  function automatic map_rsp_t map_apply(input map_op_t op);
    map_rsp_t          r;
    logic              hit;
    logic              room;
    logic [SLOT_W-1:0] at;
    r.status = lphm_pkg::STATUS_NOT_FOUND;
    r.handle = '0;
    if (op.cmd == CMD_UNUSED) return r;
    find_bucket(op.axis, op.epoch, hit, at, room);
    if (op.cmd == lphm_pkg::CMD_INSERT) begin
      if (hit) begin
        r.status = lphm_pkg::STATUS_EXISTS;
      end else if (claimed_count + 1 >= LOAD_LIMIT || !room) begin
        r.status = lphm_pkg::STATUS_FULL;
      end else begin
        if (bucket_mark[at] == lphm_pkg::MARK_EMPTY) claimed_count++;
        bucket_mark[at]   = lphm_pkg::MARK_OCCUPIED;
        bucket_axis[at]   = op.axis;
        bucket_epoch[at]  = op.epoch;
        bucket_handle[at] = op.handle & HANDLE_MASK;
        live_count++;
        r.status = lphm_pkg::STATUS_OK;
      end
    end else if (hit) begin
      r.status = lphm_pkg::STATUS_OK;
      r.handle = bucket_handle[at];
      if (op.cmd == lphm_pkg::CMD_REMOVE) begin
        bucket_mark[at]   = lphm_pkg::MARK_TOMBSTONE;
        bucket_axis[at]   = '0;
        bucket_epoch[at]  = '0;
        bucket_handle[at] = '0;
        if (live_count > 0) live_count--;
      end
    end
    return r;
  endfunction

  function automatic int pick_pause(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(15, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [lphm_pkg::KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [lphm_pkg::HANDLE_W-1:0] rand_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  task automatic draw_key_homed(input int target, output logic [lphm_pkg::KEY_W-1:0] a,
                                output logic [lphm_pkg::KEY_W-1:0] e);
    a = rand_key();
    e = rand_key();
    while (home_bucket(a, e) != target[SLOT_W-1:0]) begin
      a = rand_key();
      e = rand_key();
    end
  endtask

  task automatic add_op(input logic [lphm_pkg::CMD_W-1:0] cmd,
                        input logic [lphm_pkg::KEY_W-1:0] a,
                        input logic [lphm_pkg::KEY_W-1:0] e,
                        input logic [lphm_pkg::HANDLE_W-1:0] h,
                        input logic hold);
    map_op_t op;
    op.hold   = hold;
    op.cmd    = cmd;
    op.axis   = a;
    op.epoch  = e;
    op.handle = h;
    op_q.push_back(op);
  endtask

  task automatic add_pool_key(input logic [lphm_pkg::KEY_W-1:0] a,
                              input logic [lphm_pkg::KEY_W-1:0] e);
    pool_axis.push_back(a);
    pool_epoch.push_back(e);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("linear_probe_hash_map regression: fail");
    $finish;
  end

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_rsp.push_back(map_apply(cur_op));
        sent_count++;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (op_q.size() != 0 && !(op_q[0].hold && awaited_rsp.size() != 0)) begin
          cur_op = op_q.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.command      <= cur_op.cmd;
          req_ch.key_axis     <= cur_op.axis;
          req_ch.key_epoch    <= cur_op.epoch;
          req_ch.value_handle <= cur_op.handle;
          gap_left = pick_pause(send_burst);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end else begin
      req_ch.valid        <= 1'b0;
      req_ch.command      <= lphm_pkg::CMD_INSERT;
      req_ch.key_axis     <= '0;
      req_ch.key_epoch    <= '0;
      req_ch.value_handle <= '0;
    end
  end

  // response monitor and checker
  always @(posedge clk_i) begin
    map_rsp_t want;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_rsp.size() == 0) begin
          note_mismatch($sformatf("response %0d with no request pending", rsp_count));
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_ch.status !== want.status)
            note_mismatch($sformatf("response %0d status %0d, expected %0d",
                                    rsp_count, rsp_ch.status, want.status));
          if (rsp_ch.result_handle !== want.handle)
            note_mismatch($sformatf("response %0d handle %08h, expected %08h",
                                    rsp_count, rsp_ch.result_handle, want.handle));
        end
        rsp_count++;
      end
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 6) == 0) stall_left = pick_pause(rsp_burst);
      rsp_ch.ready <= (stall_left == 0);
    end else begin
      rsp_ch.ready <= 1'b0;
    end
  end

  initial begin
    logic [lphm_pkg::KEY_W-1:0]    ka;
    logic [lphm_pkg::KEY_W-1:0]    ke;
    logic [lphm_pkg::KEY_W-1:0]    ca [4];
    logic [lphm_pkg::KEY_W-1:0]    ce [4];
    logic [lphm_pkg::CMD_W-1:0]    cmd;
    logic [lphm_pkg::HANDLE_W-1:0] h1;
    logic [lphm_pkg::HANDLE_W-1:0] h3;
    int                            i;
    int                            k;
    int                            r;

    rst_ni <= 1'b0;
    for (i = 0; i < SLOTS; i++) begin
      bucket_mark[i]   = lphm_pkg::MARK_EMPTY;
      bucket_axis[i]   = '0;
      bucket_epoch[i]  = '0;
      bucket_handle[i] = '0;
    end
    live_count = 0;
    claimed_count = 0;
    sent_count = 0;
    rsp_count = 0;
    mismatches = 0;
    gap_left = 0;
    send_burst = 0;
    stall_left = 0;
    rsp_burst = 0;

    // chain of keys sharing the last slot, so probes wrap
    for (i = 0; i < 4; i++) draw_key_homed(SLOTS - 1, ca[i], ce[i]);
    h1 = $urandom();
    h3 = $urandom();

    // directed start
    add_op(lphm_pkg::CMD_LOOKUP, '0, '0, '1, 1'b0);
    add_op(lphm_pkg::CMD_REMOVE, KEY_ONES, KEY_ONES, '1, 1'b0);
    add_op(CMD_UNUSED, KEY_ONES, KEY_ONES, '1, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, '0, '0, '0, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, KEY_ONES, KEY_ONES, '1, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, '0, '0, 32'h5a5a_a5a5, 1'b0);
    add_op(lphm_pkg::CMD_LOOKUP, '0, '0, '1, 1'b0);
    add_op(lphm_pkg::CMD_LOOKUP, KEY_ONES, KEY_ONES, '0, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, ca[0], ce[0], $urandom(), 1'b0);
    add_op(lphm_pkg::CMD_INSERT, ca[1], ce[1], h1, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, ca[2], ce[2], $urandom(), 1'b0);
    add_op(lphm_pkg::CMD_LOOKUP, ca[2], ce[2], '0, 1'b0);
    add_op(lphm_pkg::CMD_REMOVE, ca[1], ce[1], '0, 1'b0);
    add_op(lphm_pkg::CMD_LOOKUP, ca[2], ce[2], '0, 1'b0);
    add_op(lphm_pkg::CMD_LOOKUP, ca[1], ce[1], '0, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, ca[3], ce[3], h3, 1'b0);
    add_op(lphm_pkg::CMD_LOOKUP, ca[3], ce[3], '0, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, ca[1], ce[1], ~h1, 1'b0);
    add_op(lphm_pkg::CMD_REMOVE, KEY_ONES, KEY_ONES, '0, 1'b0);
    add_op(lphm_pkg::CMD_REMOVE, KEY_ONES, KEY_ONES, '0, 1'b0);
    add_op(CMD_UNUSED, '0, '0, '0, 1'b0);
    add_op(lphm_pkg::CMD_LOOKUP, '0, '0, '0, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, '0, KEY_ONES, '1, 1'b0);
    add_op(lphm_pkg::CMD_INSERT, KEY_ONES, '0, '0, 1'b0);

    add_pool_key('0, '0);
    add_pool_key(KEY_ONES, KEY_ONES);
    add_pool_key('0, KEY_ONES);
    add_pool_key(KEY_ONES, '0);
    for (i = 0; i < 4; i++) add_pool_key(ca[i], ce[i]);
    for (i = 0; i < 12; i++) begin
      draw_key_homed((i % 3 == 2) ? 0 : SLOTS - 2 + (i % 3), ka, ke);
      add_pool_key(ka, ke);
    end
    for (i = 0; i < 24; i++) add_pool_key(rand_key(), rand_key());

    // random body over the key pool, with a few fresh keys
    for (i = 0; i < 540; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) cmd = lphm_pkg::CMD_INSERT;
      else if (r < 78) cmd = lphm_pkg::CMD_LOOKUP;
      else if (r < 95) cmd = lphm_pkg::CMD_REMOVE;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 99) < 10) begin
        ka = rand_key();
        ke = rand_key();
      end else begin
        k = $urandom_range(0, pool_axis.size() - 1);
        ka = pool_axis[k];
        ke = pool_epoch[k];
      end
      add_op(cmd, ka, ke, rand_handle(), i == 0);
    end

    // fill to the load limit, with lookups and with removes and reinserts mixed in
    for (i = 0; i < 60; i++) begin
      if (i % 6 == 5) begin
        k = $urandom_range(0, pool_axis.size() - 1);
        add_op(lphm_pkg::CMD_REMOVE, pool_axis[k], pool_epoch[k], rand_handle(), 1'b0);
        add_op(lphm_pkg::CMD_INSERT, pool_axis[k], pool_epoch[k], rand_handle(), 1'b0);
      end else if (i % 6 == 2) begin
        k = $urandom_range(0, pool_axis.size() - 1);
        add_op(lphm_pkg::CMD_LOOKUP, pool_axis[k], pool_epoch[k], rand_handle(), 1'b0);
      end else begin
        add_op(lphm_pkg::CMD_INSERT, rand_key(), rand_key(), rand_handle(), i == 0);
      end
    end
    total_ops = op_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_count != total_ops) @(posedge clk_i);
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (awaited_rsp.size() != 0)
      note_mismatch($sformatf("%0d responses never arrived", awaited_rsp.size()));
    if (mismatches == 0) begin
      $display("linear_probe_hash_map regression: pass");
    end else begin
      $display("linear_probe_hash_map regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lphm_pkg.sv
sv/lphm_if.sv
sv/linear_probe_hash_map.sv
sv/lphm_checker.sv
test/tb_top.sv
